[rtl/bycc_pkg.sv]
// Shared constants for the BGR / YCrCb color converter.
// Holds channel width, coefficient values and operation codes; depends on nothing.
`timescale 1ns / 1ps

package bycc_pkg;

    // Channel port width and default number of fraction bits per channel.
    localparam int DATA_W        = 16;
    localparam int FRAC_BITS_DEF = 15;

    // Coefficients carry this many fraction bits.
    localparam int COEF_FRAC = 16;

    // BT.601 coefficients, rounded to nearest at 16 fraction bits.
    localparam int K_YR  = 19595;   // 0.299
    localparam int K_YG  = 38470;   // 0.587
    localparam int K_YB  = 7471;    // 0.114
    localparam int K_CR  = 46727;   // 0.713
    localparam int K_CB  = 36962;   // 0.564
    localparam int K_RCR = 91947;   // 1.403
    localparam int K_GCR = 46793;   // 0.714
    localparam int K_GCB = 22544;   // 0.344
    localparam int K_BCB = 116195;  // 1.773

    // Operation codes.
    localparam logic OP_FWD = 1'b0;  // BGR to YCrCb
    localparam logic OP_INV = 1'b1;  // YCrCb to BGR

endpackage

[rtl/bgr_ycrcb_converter.sv]
// BT.601 pixel converter between BGR and YCrCb, one pixel per transfer, built on bycc_pkg.
// The block accepts a pixel in every clock while o_stall is low. The six register stages are
// input capture, coefficient multiply, weighted sum, difference and rounding, chroma multiply,
// and final rounding with saturation. Each stage holds its own valid bit and advances whenever
// it is empty or the stage after it advances, so bubbles are squeezed out and a stall at the
// output only reaches o_stall once every stage is full. Channels are unsigned fractions with
// FRAC_BITS fraction bits; results are rounded to nearest and saturated to 0..1.0 (or 65535
// when 1.0 does not fit in 16 bits), and o_clipped reports that saturation happened.
`timescale 1ns / 1ps

module bgr_ycrcb_converter #(
    parameter int FRAC_BITS = bycc_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_operation,
    input  logic [bycc_pkg::DATA_W-1:0] i_chan_a,
    input  logic [bycc_pkg::DATA_W-1:0] i_chan_b,
    input  logic [bycc_pkg::DATA_W-1:0] i_chan_c,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [bycc_pkg::DATA_W-1:0] o_out_a,
    output logic [bycc_pkg::DATA_W-1:0] o_out_b,
    output logic [bycc_pkg::DATA_W-1:0] o_out_c,
    output logic                        o_clipped
);
    import bycc_pkg::*;

    localparam int DW   = DATA_W;
    localparam int NST  = 6;
    localparam int CW   = (FRAC_BITS > DW + 1) ? FRAC_BITS : DW + 1;  // multiplier operand
    localparam int KW   = 18;                                        // signed coefficient
    localparam int PW   = CW + KW;                                   // product
    localparam int SW   = PW + 1;                                    // sum of products
    localparam int RW   = CW + 3;                                    // result before clamp
    localparam int DRW  = DW + COEF_FRAC + 1;                        // forward difference
    localparam int PRW  = DRW + KW;                                  // chroma product
    localparam int HALF = 1 << (FRAC_BITS - 1);
    localparam int ONE  = 1 << FRAC_BITS;
    localparam int TOP  = (ONE > 65535) ? 65535 : ONE;

    localparam logic signed [KW-1:0]  C_YR  = KW'(K_YR);
    localparam logic signed [KW-1:0]  C_YG  = KW'(K_YG);
    localparam logic signed [KW-1:0]  C_YB  = KW'(K_YB);
    localparam logic signed [KW-1:0]  C_CR  = KW'(K_CR);
    localparam logic signed [KW-1:0]  C_CB  = KW'(K_CB);
    localparam logic signed [KW-1:0]  C_RCR = KW'(K_RCR);
    localparam logic signed [KW-1:0]  C_GCR = KW'(K_GCR);
    localparam logic signed [KW-1:0]  C_GCB = KW'(K_GCB);
    localparam logic signed [KW-1:0]  C_BCB = KW'(K_BCB);
    localparam logic [CW-1:0]         HALF_U = CW'(HALF);
    localparam logic signed [RW-1:0]  HALF_R = RW'(HALF);
    localparam logic signed [RW-1:0]  TOP_R  = RW'(TOP);
    localparam logic [DW-1:0]         TOP_U  = DW'(TOP);
    localparam logic signed [SW-1:0]  RND16  = SW'(1 << (COEF_FRAC - 1));
    localparam logic signed [PRW-1:0] RND32  = PRW'(64'd1 << (2 * COEF_FRAC - 1));

    // Stage valid bits and per-stage advance enables.
    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_en;

    // Stage 0: captured input.
    logic          r_st0_op;
    logic [DW-1:0] r_st0_a, r_st0_b, r_st0_c;
    // Stage 1: products.
    logic                 r_st1_op;
    logic [DW-1:0]        r_st1_a, r_st1_c;
    logic signed [PW-1:0] r_st1_m0, r_st1_m1, r_st1_m2, r_st1_m3;
    // Stage 2: sums.
    logic                 r_st2_op;
    logic [DW-1:0]        r_st2_a, r_st2_c;
    logic signed [SW-1:0] r_st2_s0, r_st2_s1, r_st2_s2;
    // Stage 3: forward differences, rounded luma and inverse results.
    logic                  r_st3_op;
    logic signed [RW-1:0]  r_st3_y, r_st3_ia, r_st3_ib, r_st3_ic;
    logic signed [DRW-1:0] r_st3_dr, r_st3_db;
    // Stage 4: chroma products.
    logic                  r_st4_op;
    logic signed [RW-1:0]  r_st4_y, r_st4_ia, r_st4_ib, r_st4_ic;
    logic signed [PRW-1:0] r_st4_pr, r_st4_pb;
    // Stage 5: output register.
    logic [DW-1:0] r_out_a, r_out_b, r_out_c;
    logic          r_clip;

    always_comb begin
        w_en[NST-1] = !r_vld[NST-1] || !i_stall;
        for (int k = NST - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 0.
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_st0_op <= i_operation;
            r_st0_a  <= i_chan_a;
            r_st0_b  <= i_chan_b;
            r_st0_c  <= i_chan_c;
        end
    end

    // Stage 1: the three general multipliers take the BGR weights on a forward transfer and
    // the chroma weights on an inverse one; the fourth serves only the red term.
    logic signed [CW-1:0] w_xa, w_xb, w_xc, w_crd, w_cbd;
    logic signed [CW-1:0] w_x0, w_x1, w_x2;
    logic signed [KW-1:0] w_k0, w_k1, w_k2;
    logic signed [PW-1:0] n_m0, n_m1, n_m2, n_m3;

    always_comb begin
        w_xa  = $signed({{(CW-DW){1'b0}}, r_st0_a});
        w_xb  = $signed({{(CW-DW){1'b0}}, r_st0_b});
        w_xc  = $signed({{(CW-DW){1'b0}}, r_st0_c});
        w_crd = $signed({{(CW-DW){1'b0}}, r_st0_b} - HALF_U);
        w_cbd = $signed({{(CW-DW){1'b0}}, r_st0_c} - HALF_U);
        if (r_st0_op == OP_INV) begin
            w_x0 = w_cbd;
            w_k0 = C_BCB;
            w_x1 = w_crd;
            w_k1 = C_GCR;
            w_x2 = w_cbd;
            w_k2 = C_GCB;
        end else begin
            w_x0 = w_xa;
            w_k0 = C_YB;
            w_x1 = w_xb;
            w_k1 = C_YG;
            w_x2 = w_xc;
            w_k2 = C_YR;
        end
        n_m0 = PW'(w_x0) * PW'(w_k0);
        n_m1 = PW'(w_x1) * PW'(w_k1);
        n_m2 = PW'(w_x2) * PW'(w_k2);
        n_m3 = PW'(w_crd) * PW'(C_RCR);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_st1_op <= r_st0_op;
            r_st1_a  <= r_st0_a;
            r_st1_c  <= r_st0_c;
            r_st1_m0 <= n_m0;
            r_st1_m1 <= n_m1;
            r_st1_m2 <= n_m2;
            r_st1_m3 <= n_m3;
        end
    end

    // Stage 2.
    logic signed [SW-1:0] n_s0, n_s1, n_s2;

    always_comb begin
        if (r_st1_op == OP_INV) begin
            n_s0 = SW'(r_st1_m0);
        end else begin
            n_s0 = SW'(r_st1_m0) + SW'(r_st1_m1) + SW'(r_st1_m2);
        end
        n_s1 = -(SW'(r_st1_m1) + SW'(r_st1_m2));
        n_s2 = SW'(r_st1_m3);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_st2_op <= r_st1_op;
            r_st2_a  <= r_st1_a;
            r_st2_c  <= r_st1_c;
            r_st2_s0 <= n_s0;
            r_st2_s1 <= n_s1;
            r_st2_s2 <= n_s2;
        end
    end

    // Stage 3: a multiple of 2^16 passes through the rounding unchanged, so the luma input
    // of an inverse transfer is added after the shift.
    logic signed [SW-1:0]  w_t0, w_t1, w_t2;
    logic signed [RW-1:0]  w_q0, w_q1, w_q2, w_aext;
    logic signed [DRW-1:0] n_dr, n_db;

    always_comb begin
        w_t0   = r_st2_s0 + RND16;
        w_t1   = r_st2_s1 + RND16;
        w_t2   = r_st2_s2 + RND16;
        w_q0   = RW'(w_t0 >>> COEF_FRAC);
        w_q1   = RW'(w_t1 >>> COEF_FRAC);
        w_q2   = RW'(w_t2 >>> COEF_FRAC);
        w_aext = $signed({{(RW-DW){1'b0}}, r_st2_a});
        n_dr   = $signed({1'b0, r_st2_c, {COEF_FRAC{1'b0}}}) - $signed(r_st2_s0[DRW-1:0]);
        n_db   = $signed({1'b0, r_st2_a, {COEF_FRAC{1'b0}}}) - $signed(r_st2_s0[DRW-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_st3_op <= r_st2_op;
            r_st3_y  <= w_q0;
            r_st3_ia <= w_aext + w_q0;
            r_st3_ib <= w_aext + w_q1;
            r_st3_ic <= w_aext + w_q2;
            r_st3_dr <= n_dr;
            r_st3_db <= n_db;
        end
    end

    // Stage 4.
    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_st4_op <= r_st3_op;
            r_st4_y  <= r_st3_y;
            r_st4_ia <= r_st3_ia;
            r_st4_ib <= r_st3_ib;
            r_st4_ic <= r_st3_ic;
            r_st4_pr <= PRW'(r_st3_dr) * PRW'(C_CR);
            r_st4_pb <= PRW'(r_st3_db) * PRW'(C_CB);
        end
    end

    // Stage 5: the chroma offset of one half is a whole multiple of the rounding step, so it
    // is added after the shift.
    function automatic logic [DW:0] f_sat(input logic signed [RW-1:0] v);
        logic [DW:0] res;
        if (v < 0) begin
            res = {1'b1, {DW{1'b0}}};
        end else if (v > TOP_R) begin
            res = {1'b1, TOP_U};
        end else begin
            res = {1'b0, v[DW-1:0]};
        end
        return res;
    endfunction

    logic signed [PRW-1:0] w_pr_t, w_pb_t;
    logic signed [RW-1:0]  w_cr, w_cb, w_ra, w_rb, w_rc;
    logic [DW:0]           w_sa, w_sb, w_sc;

    always_comb begin
        w_pr_t = r_st4_pr + RND32;
        w_pb_t = r_st4_pb + RND32;
        w_cr   = RW'(w_pr_t >>> (2 * COEF_FRAC)) + HALF_R;
        w_cb   = RW'(w_pb_t >>> (2 * COEF_FRAC)) + HALF_R;
        if (r_st4_op == OP_INV) begin
            w_ra = r_st4_ia;
            w_rb = r_st4_ib;
            w_rc = r_st4_ic;
        end else begin
            w_ra = r_st4_y;
            w_rb = w_cr;
            w_rc = w_cb;
        end
        w_sa = f_sat(w_ra);
        w_sb = f_sat(w_rb);
        w_sc = f_sat(w_rc);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_out_a <= w_sa[DW-1:0];
            r_out_b <= w_sb[DW-1:0];
            r_out_c <= w_sc[DW-1:0];
            r_clip  <= w_sa[DW] | w_sb[DW] | w_sc[DW];
        end
    end

    assign o_out_a   = r_out_a;
    assign o_out_b   = r_out_b;
    assign o_out_c   = r_out_c;
    assign o_clipped = r_clip;

`ifndef SYNTHESIS
    // Back pressure reaches the input only when every stage holds a pixel.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld))
        else $error("o_stall raised while a pipeline stage is empty");

    // A pixel in the last compute stage moves to the output whenever the output is free.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NST-2] && !i_stall) |=> o_valid)
        else $error("pixel lost between final stage and output");

    // Saturation keeps every delivered channel within range.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_a <= TOP_U && o_out_b <= TOP_U && o_out_c <= TOP_U))
        else $error("output channel above saturation limit");
`endif

endmodule

[tb/bgr_ycrcb_converter_tb.sv]
// Self-checking testbench for the BGR / YCrCb pixel converter, run with its default precision.
// Depends on bycc_pkg and bgr_ycrcb_converter; predicts each pixel in fixed point and
// checks every output transfer against it under random source gaps and sink stalls.
`timescale 1ns / 1ps

module bgr_ycrcb_converter_tb;
    import bycc_pkg::*;

    localparam int     FRAC       = FRAC_BITS_DEF;
    localparam longint ONE_FX     = longint'(1) << FRAC;
    localparam longint HALF_FX    = longint'(1) << (FRAC - 1);
    localparam longint TOP_FX     = (ONE_FX > 65535) ? 65535 : ONE_FX;
    localparam int     N_RANDOM   = 1850;
    localparam int     HOLD_LEN   = 250;
    localparam int     CYCLE_CAP  = 400000;

    typedef struct packed {
        logic              op;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] c;
    } t_pixel;

    typedef struct packed {
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] c;
        logic              clip;
    } t_conv;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_valid     = 1'b0;
    logic              i_operation = OP_FWD;
    logic [DATA_W-1:0] i_chan_a    = '0;
    logic [DATA_W-1:0] i_chan_b    = '0;
    logic [DATA_W-1:0] i_chan_c    = '0;
    logic              i_stall     = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic [DATA_W-1:0] o_out_a;
    logic [DATA_W-1:0] o_out_b;
    logic [DATA_W-1:0] o_out_c;
    logic              o_clipped;

    t_pixel pixel_queue[$];
    t_conv  conv_expected[$];
    t_pixel cur_px;
    int     err_count    = 0;
    int     cycle_count  = 0;
    int     gap_left     = 0;
    bit     tx_calm      = 1'b0;
    int     stall_left   = 0;
    int     hold_left    = 0;
    int     results_seen = 0;
    bit     rx_calm      = 1'b0;

    bgr_ycrcb_converter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_operation (i_operation),
        .i_chan_a    (i_chan_a),
        .i_chan_b    (i_chan_b),
        .i_chan_c    (i_chan_c),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_a     (o_out_a),
        .o_out_b     (o_out_b),
        .o_out_c     (o_out_c),
        .o_clipped   (o_clipped)
    );

    always #5 i_clk = ~i_clk;

    // Arithmetic shift floors, which matches round-half-up for either sign.
    function automatic longint round_nearest(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    // Returns the clip flag above the saturated channel value.
    function automatic logic [DATA_W:0] clamp_chan(longint v);
        if (v < 0) begin
            return {1'b1, {DATA_W{1'b0}}};
        end
        if (v > TOP_FX) begin
            return {1'b1, DATA_W'(TOP_FX)};
        end
        return {1'b0, DATA_W'(v)};
    endfunction

    function automatic t_conv predict_conversion(t_pixel p);
        longint           a, b, c, ysum, dr, db, ra, rb, rc, crd, cbd, y16;
        logic [DATA_W:0]  sa, sb, sc;
        t_conv            r;
        a = longint'(p.a);
        b = longint'(p.b);
        c = longint'(p.c);
        if (p.op == OP_FWD) begin
            // Blue, green, red in; the chroma terms use the unrounded luma sum.
            ysum = longint'(K_YR) * c + longint'(K_YG) * b + longint'(K_YB) * a;
            dr   = c * 65536 - ysum;
            db   = a * 65536 - ysum;
            ra   = round_nearest(ysum, 16);
            rb   = round_nearest(dr * longint'(K_CR) + (HALF_FX << 32), 32);
            rc   = round_nearest(db * longint'(K_CB) + (HALF_FX << 32), 32);
        end else begin
            crd = b - HALF_FX;
            cbd = c - HALF_FX;
            y16 = a * 65536;
            ra  = round_nearest(y16 + longint'(K_BCB) * cbd, 16);
            rb  = round_nearest(y16 - longint'(K_GCR) * crd - longint'(K_GCB) * cbd, 16);
            rc  = round_nearest(y16 + longint'(K_RCR) * crd, 16);
        end
        sa     = clamp_chan(ra);
        sb     = clamp_chan(rb);
        sc     = clamp_chan(rc);
        r.a    = sa[DATA_W-1:0];
        r.b    = sb[DATA_W-1:0];
        r.c    = sc[DATA_W-1:0];
        r.clip = sa[DATA_W] | sb[DATA_W] | sc[DATA_W];
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] rand_chan();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            return DATA_W'($urandom_range(0, 32768));
        end else if (pick == 7) begin
            return ($urandom_range(0, 1) == 1) ? DATA_W'(ONE_FX) : '0;
        end
        return DATA_W'($urandom);
    endfunction

    task automatic add_pixel(logic op, logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                             logic [DATA_W-1:0] c);
        t_pixel p;
        p.op = op;
        p.a  = a;
        p.b  = b;
        p.c  = c;
        pixel_queue.push_back(p);
    endtask

    // Source side: each offered pixel is followed by a drawn number of idle cycles before the next.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            gap_left = 0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid) begin
                conv_expected.push_back(predict_conversion(cur_px));
            end
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pixel_queue.size() != 0) begin
                cur_px = pixel_queue.pop_front();
                i_operation <= cur_px.op;
                i_chan_a    <= cur_px.a;
                i_chan_b    <= cur_px.b;
                i_chan_c    <= cur_px.c;
                i_valid     <= 1'b1;
                if ($urandom_range(0, 39) == 0) begin
                    tx_calm = !tx_calm;
                end
                gap_left = tx_calm ? 0 : $urandom_range(0, 14);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Sink side: checks each output transfer and draws the stall before the next one.
    always @(posedge i_clk) begin
        t_conv got;
        t_conv want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end else begin
            if (o_valid && !i_stall) begin
                got.a    = o_out_a;
                got.b    = o_out_b;
                got.c    = o_out_c;
                got.clip = o_clipped;
                if (conv_expected.size() == 0) begin
                    $error("output transfer with no pixel pending");
                    err_count++;
                end else begin
                    want = conv_expected.pop_front();
                    if (got.a !== want.a) begin
                        $error("out_a: expected %0d, got %0d", want.a, got.a);
                        err_count++;
                    end
                    if (got.b !== want.b) begin
                        $error("out_b: expected %0d, got %0d", want.b, got.b);
                        err_count++;
                    end
                    if (got.c !== want.c) begin
                        $error("out_c: expected %0d, got %0d", want.c, got.c);
                        err_count++;
                    end
                    if (got.clip !== want.clip) begin
                        $error("clipped: expected %0d, got %0d", want.clip, got.clip);
                        err_count++;
                    end
                end
                results_seen++;
                // A long hold-off lets the pipeline fill so that the input gets stalled.
                if (results_seen == 300 || results_seen == 1300) begin
                    hold_left = HOLD_LEN;
                end
                if ($urandom_range(0, 39) == 0) begin
                    rx_calm = !rx_calm;
                end
                stall_left = rx_calm ? 0 : $urandom_range(0, 14);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        // Corners: black, white, primaries, inputs above 1.0 and saturating chroma.
        add_pixel(OP_FWD, 16'd0, 16'd0, 16'd0);
        add_pixel(OP_FWD, 16'd32768, 16'd32768, 16'd32768);
        add_pixel(OP_FWD, 16'd32768, 16'd0, 16'd0);
        add_pixel(OP_FWD, 16'd0, 16'd32768, 16'd0);
        add_pixel(OP_FWD, 16'd0, 16'd0, 16'd32768);
        add_pixel(OP_FWD, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_pixel(OP_FWD, 16'hFFFF, 16'd0, 16'd0);
        add_pixel(OP_FWD, 16'd0, 16'd0, 16'hFFFF);
        add_pixel(OP_FWD, 16'h5555, 16'hAAAA, 16'h5555);
        add_pixel(OP_INV, 16'd0, 16'd16384, 16'd16384);
        add_pixel(OP_INV, 16'd32768, 16'd16384, 16'd16384);
        add_pixel(OP_INV, 16'd0, 16'd0, 16'd0);
        add_pixel(OP_INV, 16'd32768, 16'd32768, 16'd32768);
        add_pixel(OP_INV, 16'd16384, 16'd0, 16'd32768);
        add_pixel(OP_INV, 16'd16384, 16'd32768, 16'd0);
        add_pixel(OP_INV, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_pixel(OP_INV, 16'd0, 16'hFFFF, 16'hFFFF);
        add_pixel(OP_INV, 16'hAAAA, 16'h5555, 16'hAAAA);
        add_pixel(OP_INV, 16'd16384, 16'd16384, 16'd16384);
        for (int n = 0; n < N_RANDOM; n++) begin
            add_pixel(($urandom_range(0, 1) == 1) ? OP_INV : OP_FWD,
                      rand_chan(), rand_chan(), rand_chan());
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (pixel_queue.size() != 0 || i_valid) begin
            @(negedge i_clk);
        end
        while (conv_expected.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (20) @(negedge i_clk);

        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
